### sv/sm83_alu_flag_unit_macros.svh
// Assertion macros shared by the ALU flag unit RTL.
`ifndef SM83_ALU_FLAG_UNIT_MACROS_SVH
`define SM83_ALU_FLAG_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SM83_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SM83_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/sm83_alu_pkg.sv
// Shared types, operation codes and constants of the SM83 ALU flag unit.
`default_nettype none
package sm83_alu_pkg;

	localparam int KIND_W = 5;
	localparam int WORD_W = 16;
	localparam int BYTE_W = 8;
	localparam int BSEL_W = 3;

	// Operation codes; codes above K_LD_A are no-ops
	typedef enum logic [KIND_W-1:0] {
		K_ADD   = 5'd0,
		K_ADC   = 5'd1,
		K_SUB   = 5'd2,
		K_SBC   = 5'd3,
		K_CP    = 5'd4,
		K_AND   = 5'd5,
		K_OR    = 5'd6,
		K_XOR   = 5'd7,
		K_INC8  = 5'd8,
		K_DEC8  = 5'd9,
		K_ADD16 = 5'd10,
		K_INC16 = 5'd11,
		K_DEC16 = 5'd12,
		K_DAA   = 5'd13,
		K_CPL   = 5'd14,
		K_SCF   = 5'd15,
		K_CCF   = 5'd16,
		K_RLC   = 5'd17,
		K_RRC   = 5'd18,
		K_RL    = 5'd19,
		K_RR    = 5'd20,
		K_SLA   = 5'd21,
		K_SRA   = 5'd22,
		K_SRL   = 5'd23,
		K_SWAP  = 5'd24,
		K_BIT   = 5'd25,
		K_RES   = 5'd26,
		K_SET   = 5'd27,
		K_LD_A  = 5'd28
	} kind_t;

	// Decimal adjust constants
	localparam logic [BYTE_W-1:0] DAA_LO_ADJ = 8'h06;
	localparam logic [BYTE_W-1:0] DAA_HI_ADJ = 8'h60;
	localparam logic [BYTE_W-1:0] BCD_MAX    = 8'h99;
	localparam logic [3:0]        DIGIT_MAX  = 4'h9;
	localparam logic [BYTE_W-1:0] BYTE_ONES  = 8'hFF;

	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} flags_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [WORD_W-1:0] operand;
		logic [WORD_W-1:0] second_operand;
		logic [BSEL_W-1:0] bit_index;
	} cmd_t;

	typedef struct packed {
		logic [WORD_W-1:0] result;
		logic [BYTE_W-1:0] accumulator;
		logic              writes_back;
		flags_t            flags;
	} rsp_t;

endpackage
`default_nettype wire

### sv/sm83_alu_if.sv
// Handshake interfaces for the ALU command and result channels.
`default_nettype none
interface sm83_alu_cmd_if;
	import sm83_alu_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [WORD_W-1:0] operand;
	logic [WORD_W-1:0] second_operand;
	logic [BSEL_W-1:0] bit_index;

	modport source (output valid, kind, operand, second_operand, bit_index, input ready);
	modport sink (input valid, kind, operand, second_operand, bit_index, output ready);
endinterface

interface sm83_alu_rsp_if;
	import sm83_alu_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] result;
	logic [BYTE_W-1:0] accumulator;
	logic              writes_back;
	logic              zero_flag;
	logic              subtract_flag;
	logic              half_carry_flag;
	logic              carry_flag;

	modport source (output valid, result, accumulator, writes_back, zero_flag,
		subtract_flag, half_carry_flag, carry_flag, input ready);
	modport sink (input valid, result, accumulator, writes_back, zero_flag,
		subtract_flag, half_carry_flag, carry_flag, output ready);
endinterface
`default_nettype wire

### sv/sm83_alu_core.sv
// Combinational SM83 datapath: one operation on A, operand and flags.
`default_nettype none
module sm83_alu_core (
	input  sm83_alu_pkg::cmd_t   cmd_item,
	input  logic [7:0]           acc,
	input  sm83_alu_pkg::flags_t flags,
	output sm83_alu_pkg::rsp_t   rsp_item
);
	import sm83_alu_pkg::*;

	logic [BYTE_W-1:0] v;
	logic [WORD_W-1:0] word;
	logic [WORD_W-1:0] dest;
	logic              cin;

	logic [BYTE_W:0]   sum9;
	logic [4:0]        hsum;
	logic [BYTE_W:0]   dif9;
	logic [4:0]        hdif;
	logic [WORD_W:0]   sum17;
	logic [12:0]       hsum16;
	logic [BYTE_W-1:0] bit_mask;

	logic              daa_hi;
	logic              daa_lo;
	logic [BYTE_W-1:0] daa_a1;
	logic [BYTE_W-1:0] daa_res;

	logic [BYTE_W-1:0] sh_res;
	logic              sh_c;

	logic [BYTE_W-1:0] a_nx;
	flags_t            f_nx;
	logic [WORD_W-1:0] res;
	logic              wb;

	assign v    = cmd_item.operand[BYTE_W-1:0];
	assign word = cmd_item.operand;
	assign dest = cmd_item.second_operand;

	// carry in only for ADC and SBC
	assign cin = flags.c & ((cmd_item.kind == K_ADC) || (cmd_item.kind == K_SBC));

	// 8-bit add and subtract with nibble carries
	assign sum9 = {1'b0, acc} + {1'b0, v} + {{BYTE_W{1'b0}}, cin};
	assign hsum = {1'b0, acc[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
	assign dif9 = {1'b0, acc} - {1'b0, v} - {{BYTE_W{1'b0}}, cin};
	assign hdif = {1'b0, acc[3:0]} - {1'b0, v[3:0]} - {4'd0, cin};

	// 16-bit add, carries out of bits 11 and 15
	assign sum17  = {1'b0, dest} + {1'b0, word};
	assign hsum16 = {1'b0, dest[11:0]} + {1'b0, word[11:0]};

	assign bit_mask = BYTE_W'(1) << cmd_item.bit_index;

	// Decimal adjust: high correction first, low digit checked on its output
	always_comb begin
		if (!flags.n) begin
			daa_hi  = flags.c || (acc > BCD_MAX);
			daa_a1  = daa_hi ? acc + DAA_HI_ADJ : acc;
			daa_lo  = flags.h || (daa_a1[3:0] > DIGIT_MAX);
			daa_res = daa_lo ? daa_a1 + DAA_LO_ADJ : daa_a1;
		end else begin
			daa_hi  = flags.c;
			daa_a1  = daa_hi ? acc - DAA_HI_ADJ : acc;
			daa_lo  = flags.h;
			daa_res = daa_lo ? daa_a1 - DAA_LO_ADJ : daa_a1;
		end
	end

	// Rotate, shift and swap unit on the operand byte
	always_comb begin
		sh_res = v;
		sh_c   = 1'b0;
		case (cmd_item.kind)
			K_RLC: begin
				sh_res = {v[6:0], v[7]};
				sh_c   = v[7];
			end
			K_RRC: begin
				sh_res = {v[0], v[7:1]};
				sh_c   = v[0];
			end
			K_RL: begin
				sh_res = {v[6:0], flags.c};
				sh_c   = v[7];
			end
			K_RR: begin
				sh_res = {flags.c, v[7:1]};
				sh_c   = v[0];
			end
			K_SLA: begin
				sh_res = {v[6:0], 1'b0};
				sh_c   = v[7];
			end
			K_SRA: begin
				sh_res = {v[7], v[7:1]};
				sh_c   = v[0];
			end
			K_SRL: begin
				sh_res = {1'b0, v[7:1]};
				sh_c   = v[0];
			end
			K_SWAP: begin
				sh_res = {v[3:0], v[7:4]};
				sh_c   = 1'b0;
			end
			default: begin
				sh_res = v;
				sh_c   = 1'b0;
			end
		endcase
	end

	// Operation decode: new A, flags, result and write-back mark
	always_comb begin
		a_nx = acc;
		f_nx = flags;
		res  = '0;
		wb   = 1'b0;
		unique case (cmd_item.kind)
			K_ADD, K_ADC: begin
				a_nx = sum9[BYTE_W-1:0];
				f_nx = '{z: (sum9[BYTE_W-1:0] == '0), n: 1'b0, h: hsum[4], c: sum9[BYTE_W]};
				res  = {8'd0, sum9[BYTE_W-1:0]};
			end
			K_SUB, K_SBC, K_CP: begin
				if (cmd_item.kind != K_CP) begin
					a_nx = dif9[BYTE_W-1:0];
				end
				f_nx = '{z: (dif9[BYTE_W-1:0] == '0), n: 1'b1, h: hdif[4], c: dif9[BYTE_W]};
				res  = {8'd0, dif9[BYTE_W-1:0]};
			end
			K_AND: begin
				a_nx = acc & v;
				f_nx = '{z: ((acc & v) == '0), n: 1'b0, h: 1'b1, c: 1'b0};
				res  = {8'd0, acc & v};
			end
			K_OR: begin
				a_nx = acc | v;
				f_nx = '{z: ((acc | v) == '0), n: 1'b0, h: 1'b0, c: 1'b0};
				res  = {8'd0, acc | v};
			end
			K_XOR: begin
				a_nx = acc ^ v;
				f_nx = '{z: ((acc ^ v) == '0), n: 1'b0, h: 1'b0, c: 1'b0};
				res  = {8'd0, acc ^ v};
			end
			K_INC8: begin
				res  = {8'd0, v + 8'd1};
				f_nx = '{z: (v == BYTE_ONES), n: 1'b0, h: (v[3:0] == 4'hF), c: flags.c};
				wb   = 1'b1;
			end
			K_DEC8: begin
				res  = {8'd0, v - 8'd1};
				f_nx = '{z: (v == 8'd1), n: 1'b1, h: (v[3:0] == 4'h0), c: flags.c};
				wb   = 1'b1;
			end
			K_ADD16: begin
				res  = sum17[WORD_W-1:0];
				f_nx = '{z: flags.z, n: 1'b0, h: hsum16[12], c: sum17[WORD_W]};
				wb   = 1'b1;
			end
			K_INC16: begin
				res = word + 16'd1;
				wb  = 1'b1;
			end
			K_DEC16: begin
				res = word - 16'd1;
				wb  = 1'b1;
			end
			K_DAA: begin
				a_nx = daa_res;
				f_nx = '{z: (daa_res == '0), n: flags.n, h: 1'b0, c: flags.c | daa_hi};
				res  = {8'd0, daa_res};
			end
			K_CPL: begin
				a_nx = acc ^ BYTE_ONES;
				f_nx = '{z: flags.z, n: 1'b1, h: 1'b1, c: flags.c};
				res  = {8'd0, acc ^ BYTE_ONES};
			end
			K_SCF: begin
				f_nx = '{z: flags.z, n: 1'b0, h: 1'b0, c: 1'b1};
			end
			K_CCF: begin
				f_nx = '{z: flags.z, n: 1'b0, h: 1'b0, c: !flags.c};
			end
			K_RLC, K_RRC, K_RL, K_RR, K_SLA, K_SRA, K_SRL, K_SWAP: begin
				res  = {8'd0, sh_res};
				f_nx = '{z: (sh_res == '0), n: 1'b0, h: 1'b0, c: sh_c};
				wb   = 1'b1;
			end
			K_BIT: begin
				f_nx = '{z: ((v & bit_mask) == '0), n: 1'b0, h: 1'b1, c: flags.c};
			end
			K_RES: begin
				res = {8'd0, v & ~bit_mask};
				wb  = 1'b1;
			end
			K_SET: begin
				res = {8'd0, v | bit_mask};
				wb  = 1'b1;
			end
			K_LD_A: begin
				a_nx = v;
				res  = {8'd0, v};
			end
			default: begin
				// unused codes leave everything as it was
				a_nx = acc;
				f_nx = flags;
				res  = '0;
				wb   = 1'b0;
			end
		endcase
	end

	assign rsp_item = '{result: res, accumulator: a_nx, writes_back: wb, flags: f_nx};

endmodule
`default_nettype wire

### sv/sm83_alu_flag_unit.sv
// Path: an accepted item passes the input register, then the result register, where its result is valid.
// Throughput: one item per cycle while rsp.ready is high; A and flags update as an item moves into the result register,
// so the next item reads them through the single combinational ALU pass.
// Reset (arst_n low, asynchronous): A and all flags clear, both stages empty.
// Backpressure on the result side holds both stages; cmd.ready falls only when both are full.
`default_nettype none
module sm83_alu_flag_unit (
	input  logic         clk,
	input  logic         arst_n,
	sm83_alu_cmd_if.sink   cmd,
	sm83_alu_rsp_if.source rsp
);
	import sm83_alu_pkg::*;
	`include "sm83_alu_flag_unit_macros.svh"

	logic              valid_s1;
	cmd_t              cmd_s1;
	logic              valid_s2;
	rsp_t              rsp_s2;
	logic [BYTE_W-1:0] acc_q;
	flags_t            flags_q;
	rsp_t              alu_out;
	logic              adv_s1;
	logic              load_s2;

	// Stage handshakes
	assign adv_s1    = !valid_s2 || rsp.ready;
	assign load_s2   = valid_s1 && adv_s1;
	assign cmd.ready = !valid_s1 || adv_s1;

	// Input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= '{kind: cmd.kind, operand: cmd.operand,
				second_operand: cmd.second_operand, bit_index: cmd.bit_index};
		end
	end

	sm83_alu_core u_core (
		.cmd_item (cmd_s1),
		.acc      (acc_q),
		.flags    (flags_q),
		.rsp_item (alu_out)
	);

	// Result register valid and architectural A and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			acc_q    <= '0;
			flags_q  <= '0;
		end else begin
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
			if (load_s2) begin
				acc_q   <= alu_out.accumulator;
				flags_q <= alu_out.flags;
			end
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (load_s2) begin
			rsp_s2 <= alu_out;
		end
	end

	assign rsp.valid           = valid_s2;
	assign rsp.result          = rsp_s2.result;
	assign rsp.accumulator     = rsp_s2.accumulator;
	assign rsp.writes_back     = rsp_s2.writes_back;
	assign rsp.zero_flag       = rsp_s2.flags.z;
	assign rsp.subtract_flag   = rsp_s2.flags.n;
	assign rsp.half_carry_flag = rsp_s2.flags.h;
	assign rsp.carry_flag      = rsp_s2.flags.c;

	// Checks
	`SM83_ASSERT_NEXT(a_acc_tracks_result, load_s2, acc_q == rsp_s2.accumulator,
		"A register differs from the item just registered")
	`SM83_ASSERT_NEXT(a_flags_track_result, load_s2, flags_q == rsp_s2.flags,
		"flag register differs from the item just registered")
	`SM83_ASSERT_NEXT(a_state_held_on_stall, valid_s1 && !adv_s1,
		$stable(acc_q) && $stable(flags_q), "A or flags moved while the item was stalled")
	`SM83_ASSERT_NOW(a_ready_only_when_full, !cmd.ready, valid_s1 && valid_s2 && !rsp.ready,
		"input stalled while a stage was free")

endmodule
`default_nettype wire
